// ----- design/delimiter_frame_buffer_core_defines.svh -----
// Assertion macros shared by the delimiter frame buffer modules.
// No dependencies; included by files that carry concurrent assertions.
`ifndef DELIMITER_FRAME_BUFFER_CORE_DEFINES_SVH
`define DELIMITER_FRAME_BUFFER_CORE_DEFINES_SVH

// Concurrent check on the rising edge, gated off while reset is low
`define DFB_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// Same check on the standard clock and reset names of this block
`define DFB_ASSERT_STD(label, prop, msg) \
  `DFB_ASSERT(label, clk_i, rst_ni, prop, msg)

`endif

// ----- design/dfb_pkg.sv -----
// Shared types and constants of the delimiter frame buffer.
// No dependencies; used by the top level, dfb_detect, dfb_table and the bench.
`timescale 1ns / 1ps
`default_nettype none

package dfb_pkg;

  // Fixed field widths
  localparam int FRAME_SIZE_W = 13;
  localparam int SEP_LEN_W    = 4;
  localparam int PATTERN_W    = 64;
  localparam int OFFSET_W     = 15;
  localparam int SKIP_W       = 8;
  localparam int SKIP_MAX     = 255;
  localparam int CONSUME_W    = 9;
  localparam int CFG_IDX_W    = 2;
  localparam int IN_TDATA_W   = 8;
  localparam int OUT_TDATA_W  = 40;
  localparam int OUT_PAD_W    = OUT_TDATA_W - 2 * OFFSET_W - SKIP_W;

  // Register reset values
  localparam logic [FRAME_SIZE_W-1:0] FRAME_SIZE_RST = 13'd1024;
  localparam logic [SEP_LEN_W-1:0]    SEP_LEN_RST    = 4'd1;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FIXED_MODE  = 2'd0,
    REG_FRAME_SIZE  = 2'd1,
    REG_SEP_LENGTH  = 2'd2,
    REG_SEP_PATTERN = 2'd3
  } cfg_reg_e;

  // Input word kinds
  typedef enum logic {
    FUNC_PUSH  = 1'b0,
    FUNC_FETCH = 1'b1
  } func_e;

  // Control sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RD_FIRST,
    ST_RD_NEXT
  } state_e;

  typedef struct packed {
    logic                    fixed_mode;
    logic [FRAME_SIZE_W-1:0] frame_size;
    logic [SEP_LEN_W-1:0]    sep_length;
    logic [PATTERN_W-1:0]    sep_pattern;
  } cfg_t;

  // Boundary seen on the byte just pushed
  typedef struct packed {
    logic hit;
    logic may_drop;
  } bnd_t;

  // Start table read requests from the sequencer
  typedef struct packed {
    logic start;
    logic second;
  } rd_cmd_t;

  // Fetch status latched when a fetch word is taken
  typedef struct packed {
    logic              found;
    logic [SKIP_W-1:0] skipped;
  } fetch_sts_t;

endpackage

`default_nettype wire

// ----- design/delimiter_frame_buffer_core.sv -----
// Top level of the delimiter frame buffer: config registers, sequencer, output register.
// Depends on dfb_pkg, dfb_detect, dfb_table and the assertion macro header.
//
// Channel  Dir  Handshake              Payload
// s_axis   in   tvalid/tready          tdata: data_byte; tuser: func
// m_axis   out  tvalid/tready          tdata: offset, length, skipped; tuser: found
// cfg      in   cfg_valid_i/ready_o    cfg_index_i, cfg_data_i
//
// Pushes are taken while the sequencer is idle and can follow back to back.
// A fetch word makes two reads of the start table RAM on its single read port, the
// first as it is taken and the second in ST_RD_FIRST; in ST_RD_NEXT the result moves
// into the output register once that is free. Pushes are taken while a result waits
// in the output register; a second fetch stalls in ST_RD_NEXT until that register drains.
// Reset clears the control state; the ring store is not cleared, the nine-entry start
// table reads zero until written via per-entry valid bits.
`timescale 1ns / 1ps
`default_nettype none
`include "delimiter_frame_buffer_core_defines.svh"

module delimiter_frame_buffer_core #(
  parameter int MAX_FRAMES = 8,
  parameter int RING_BYTES = 32768,
  parameter int SEP_MAX    = 8
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  // stream in
  input  wire logic                                s_axis_tvalid,
  output logic                                     s_axis_tready,
  input  wire logic [dfb_pkg::IN_TDATA_W-1:0]      s_axis_tdata,   // [7:0] data_byte
  input  wire logic                                s_axis_tuser,   // [0] func
  // frame descriptors out
  output logic                                     m_axis_tvalid,
  input  wire logic                                m_axis_tready,
  output logic      [dfb_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,   // [14:0] frame_offset,
                                                                   // [29:15] frame_length,
                                                                   // [37:30] skipped_frames,
                                                                   // [39:38] zero
  output logic                                     m_axis_tuser,   // [0] frame_found
  // configuration writes
  input  wire logic                                cfg_valid_i,
  output logic                                     cfg_ready_o,
  input  wire logic [dfb_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  wire logic [dfb_pkg::PATTERN_W-1:0]       cfg_data_i
);

  localparam int AW = $clog2(RING_BYTES);
  localparam int OW = dfb_pkg::OFFSET_W;

  dfb_pkg::cfg_t       cfg_q;
  dfb_pkg::state_e     state_q, state_d;
  dfb_pkg::rd_cmd_t    rd_cmd;
  dfb_pkg::bnd_t       bnd;
  dfb_pkg::fetch_sts_t sts;

  logic          in_acc, push, out_free, out_load;
  logic [AW-1:0] pos, last_start;
  logic [OW-1:0] offset, length;
  logic          m_valid_q;
  logic [dfb_pkg::OUT_TDATA_W-1:0] m_data_q;
  logic          m_user_q;

  // Configuration registers
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.fixed_mode  <= 1'b1;
      cfg_q.frame_size  <= dfb_pkg::FRAME_SIZE_RST;
      cfg_q.sep_length  <= dfb_pkg::SEP_LEN_RST;
      cfg_q.sep_pattern <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (dfb_pkg::cfg_reg_e'(cfg_index_i))
        dfb_pkg::REG_FIXED_MODE:  cfg_q.fixed_mode  <= cfg_data_i[0];
        dfb_pkg::REG_FRAME_SIZE:  cfg_q.frame_size  <= cfg_data_i[dfb_pkg::FRAME_SIZE_W-1:0];
        dfb_pkg::REG_SEP_LENGTH:  cfg_q.sep_length  <= cfg_data_i[dfb_pkg::SEP_LEN_W-1:0];
        dfb_pkg::REG_SEP_PATTERN: cfg_q.sep_pattern <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Sequencer next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      dfb_pkg::ST_IDLE: begin
        if (rd_cmd.start) state_d = dfb_pkg::ST_RD_FIRST;
      end
      dfb_pkg::ST_RD_FIRST: begin
        state_d = dfb_pkg::ST_RD_NEXT;
      end
      dfb_pkg::ST_RD_NEXT: begin
        if (out_free) state_d = dfb_pkg::ST_IDLE;
      end
      default: state_d = dfb_pkg::ST_IDLE;
    endcase
  end

  // Sequencer outputs
  always_comb begin
    s_axis_tready = (state_q == dfb_pkg::ST_IDLE);
    in_acc        = s_axis_tvalid && s_axis_tready;
    push          = in_acc && (s_axis_tuser == dfb_pkg::FUNC_PUSH);
    rd_cmd.start  = in_acc && (s_axis_tuser == dfb_pkg::FUNC_FETCH);
    rd_cmd.second = (state_q == dfb_pkg::ST_RD_FIRST);
    out_free      = !m_valid_q || m_axis_tready;
    out_load      = (state_q == dfb_pkg::ST_RD_NEXT) && out_free;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= dfb_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (out_load) begin
      m_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      m_data_q <= {{dfb_pkg::OUT_PAD_W{1'b0}}, sts.skipped, length, offset};
      m_user_q <= sts.found;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;
  assign m_axis_tuser  = m_user_q;

  dfb_detect #(
    .RING_BYTES(RING_BYTES),
    .SEP_MAX   (SEP_MAX)
  ) u_detect (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .byte_i      (s_axis_tdata),
    .cfg_i       (cfg_q),
    .last_start_i(last_start),
    .bnd_o       (bnd),
    .pos_o       (pos)
  );

  dfb_table #(
    .MAX_FRAMES(MAX_FRAMES),
    .RING_BYTES(RING_BYTES)
  ) u_table (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .bnd_i       (bnd),
    .pos_i       (pos),
    .last_start_o(last_start),
    .rd_cmd_i    (rd_cmd),
    .sts_o       (sts),
    .offset_o    (offset),
    .length_o    (length)
  );

  // A fetch walks both table reads in order
  `DFB_ASSERT_STD(a_fetch_seq,
    rd_cmd.start |=> (state_q == dfb_pkg::ST_RD_FIRST) ##1 (state_q == dfb_pkg::ST_RD_NEXT),
    "fetch did not step through both table reads")
  // A push never holds the input side
  `DFB_ASSERT_STD(a_push_single, push |=> s_axis_tready, "push held the input side")
  // A result only loads from the last fetch state
  `DFB_ASSERT_STD(a_load_state, $rose(m_valid_q) |-> $past(state_q == dfb_pkg::ST_RD_NEXT),
    "result loaded outside the fetch sequence")

endmodule

`default_nettype wire

// ----- design/dfb_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module dfb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Read port, registered: data follows in the cycle after the address; holds while idle
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

`default_nettype wire

// ----- design/dfb_detect.sv -----
// Byte side: ring store writes, recent-byte window and boundary detection.
// Depends on dfb_pkg and dfb_ram.
`timescale 1ns / 1ps
`default_nettype none

module dfb_detect #(
  parameter int RING_BYTES = 32768,
  parameter int SEP_MAX    = 8
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          push_i,
  input  wire logic [7:0]                    byte_i,
  input  wire dfb_pkg::cfg_t                 cfg_i,
  input  wire logic [$clog2(RING_BYTES)-1:0] last_start_i,
  output dfb_pkg::bnd_t                      bnd_o,
  output logic      [$clog2(RING_BYTES)-1:0] pos_o
);

  localparam int AW   = $clog2(RING_BYTES);
  localparam int AW1  = AW + 1;
  localparam int WW   = $clog2(SEP_MAX + 1);
  localparam int RW   = 8 * SEP_MAX;
  localparam int LW   = dfb_pkg::SEP_LEN_W;
  localparam int FW   = dfb_pkg::FRAME_SIZE_W;
  localparam int CMPW = ((AW > FW) ? AW : FW) + 1;

  logic [RW-1:0]   recent_q, recent_d;
  logic [RW+7:0]   shift_cat;
  logic [WW-1:0]   warm_q, warm_d;
  logic [AW-1:0]   wp_q, wp_d;
  logic [LW-1:0]   len_eff;
  logic [AW-1:0]   lm1;
  logic [AW-1:0]   pos_sep;
  logic [AW:0]     diff_w;
  logic [CMPW-1:0] fs_ext;
  logic            sep_match;
  logic            sep_hit;
  logic            fix_hit;

  // Next window, warmup and write position for the byte being pushed
  always_comb begin
    shift_cat = {byte_i, recent_q};
    recent_d  = shift_cat[RW+7:8];
    warm_d    = (warm_q < WW'(SEP_MAX)) ? warm_q + 1'b1 : warm_q;
    wp_d      = (wp_q == AW'(RING_BYTES - 1)) ? '0 : wp_q + 1'b1;
  end

  // Separator compare: one parallel match per possible length
  always_comb begin
    logic hit_l;
    len_eff   = (cfg_i.sep_length > LW'(SEP_MAX)) ? LW'(SEP_MAX) : cfg_i.sep_length;
    sep_match = 1'b0;
    for (int l = 1; l <= SEP_MAX; l++) begin
      hit_l = 1'b1;
      for (int k = 0; k < l; k++) begin
        if (recent_d[(SEP_MAX - l + k) * 8 +: 8] != cfg_i.sep_pattern[k * 8 +: 8]) begin
          hit_l = 1'b0;
        end
      end
      if (len_eff == LW'(l)) begin
        sep_match = hit_l;
      end
    end
    sep_hit = !cfg_i.fixed_mode && (len_eff != '0) && (LW'(warm_d) >= len_eff) && sep_match;
  end

  // Separator boundary sits on the separator's first byte, wrapped
  always_comb begin
    lm1 = AW'(len_eff - 1'b1);
    if (wp_q >= lm1) begin
      pos_sep = wp_q - lm1;
    end else begin
      pos_sep = AW'({1'b0, wp_q} + AW1'(RING_BYTES) - {1'b0, lm1});
    end
  end

  // Fixed mode: distance from the newest boundary to the new write position
  always_comb begin
    if (wp_d >= last_start_i) begin
      diff_w = {1'b0, wp_d} - {1'b0, last_start_i};
    end else begin
      diff_w = {1'b0, wp_d} + AW1'(RING_BYTES) - {1'b0, last_start_i};
    end
    fs_ext  = CMPW'(cfg_i.frame_size);
    fix_hit = cfg_i.fixed_mode && (fs_ext != '0) && (fs_ext < CMPW'(RING_BYTES)) &&
              (CMPW'(diff_w) == fs_ext);
  end

  assign bnd_o.hit      = push_i && (fix_hit || sep_hit);
  assign bnd_o.may_drop = !cfg_i.fixed_mode;
  assign pos_o          = cfg_i.fixed_mode ? wp_d : pos_sep;

  // Byte side state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      recent_q <= '0;
      warm_q   <= '0;
      wp_q     <= '0;
    end else if (push_i) begin
      recent_q <= recent_d;
      warm_q   <= warm_d;
      wp_q     <= wp_d;
    end
  end

  // Ring store; written on every push, its read port is tied off in this block
  dfb_ram #(
    .WIDTH(8),
    .DEPTH(RING_BYTES)
  ) u_ring (
    .clk_i  (clk_i),
    .we_i   (push_i),
    .waddr_i(wp_q),
    .wdata_i(byte_i),
    .re_i   (1'b0),
    .raddr_i(wp_q),
    .rdata_o()
  );

endmodule

`default_nettype wire

// ----- design/dfb_table.sv -----
// Frame start table: RAM of boundaries, head/count/consume bookkeeping, fetch reads.
// Depends on dfb_pkg, dfb_ram and the assertion macro header.
`timescale 1ns / 1ps
`default_nettype none
`include "delimiter_frame_buffer_core_defines.svh"

module dfb_table #(
  parameter int MAX_FRAMES = 8,
  parameter int RING_BYTES = 32768
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             push_i,
  input  wire dfb_pkg::bnd_t                    bnd_i,
  input  wire logic [$clog2(RING_BYTES)-1:0]    pos_i,
  output logic      [$clog2(RING_BYTES)-1:0]    last_start_o,
  input  wire dfb_pkg::rd_cmd_t                 rd_cmd_i,
  output dfb_pkg::fetch_sts_t                   sts_o,
  output logic      [dfb_pkg::OFFSET_W-1:0]     offset_o,
  output logic      [dfb_pkg::OFFSET_W-1:0]     length_o
);

  localparam int SLOTS = MAX_FRAMES + 1;
  localparam int SW    = $clog2(SLOTS);
  localparam int SW1   = SW + 1;
  localparam int AW    = $clog2(RING_BYTES);
  localparam int AW1   = AW + 1;
  localparam int CW    = dfb_pkg::CONSUME_W;
  localparam int CW1   = CW + 1;
  localparam int OW    = dfb_pkg::OFFSET_W;
  localparam int KW    = dfb_pkg::SKIP_W;
  localparam logic [CW:0] FloorWide = -(CW1'(dfb_pkg::SKIP_MAX));

  // (a + b) modulo the slot count, a below SLOTS, b at most SLOTS
  function automatic logic [SW-1:0] slot_add(input logic [SW-1:0] a, input logic [SW:0] b);
    logic [SW:0] s;
    s = {1'b0, a} + b;
    if (s >= SW1'(SLOTS)) begin
      s = s - SW1'(SLOTS);
    end
    return s[SW-1:0];
  endfunction

  logic [SW-1:0]    head_q, fc_q;
  logic [CW-1:0]    consume_q;
  logic [SLOTS-1:0] vld_q;
  logic [AW-1:0]    last_start_q;
  logic             found_q;
  logic [KW-1:0]    skip_q;
  logic [SW-1:0]    second_q;
  logic             vld_rd_q;
  logic [AW-1:0]    first_q;

  // push path
  logic          full, add, drop, flush;
  logic [SW-1:0] head1, head2, fc1, fc2, fc3, delta, waddr;
  logic [SW:0]   lower;
  logic [CW:0]   cons_wide;
  logic [CW-1:0] cons_push;

  // fetch path
  logic          neg, found;
  logic [CW-1:0] cons_neg, cons_fetch;
  logic [SW-1:0] c;
  logic [SW:0]   c_next;
  logic [SW-1:0] raddr;
  logic          re;
  logic [AW-1:0] rdata, rd_word;
  logic [AW:0]   dsum;

  // Boundary insert, oldest-drop and flush for one pushed byte
  always_comb begin
    full      = fc_q >= SW'(MAX_FRAMES);
    add       = bnd_i.hit && !(full && !bnd_i.may_drop);
    drop      = add && full;
    head1     = drop ? slot_add(head_q, SW1'(1)) : head_q;
    fc1       = drop ? fc_q - 1'b1 : fc_q;
    fc2       = add ? fc1 + 1'b1 : fc1;
    waddr     = slot_add(head1, {1'b0, fc2});
    flush     = (fc2 >= SW'(MAX_FRAMES - 1)) && (fc2 != '0);
    delta     = fc2 - 1'b1;
    head2     = flush ? slot_add(head1, {1'b0, delta}) : head1;
    fc3       = flush ? SW'(1) : fc2;
    lower     = SW1'(drop) + (flush ? {1'b0, delta} : '0);
    cons_wide = {consume_q[CW-1], consume_q} - CW1'(lower);
    cons_push = ($signed(cons_wide) < $signed(FloorWide)) ? FloorWide[CW-1:0]
                                                          : cons_wide[CW-1:0];
  end

  // Fetch decision: clear the drop count, pick the next unsent frame
  always_comb begin
    neg        = consume_q[CW-1];
    cons_neg   = '0 - consume_q;
    c          = neg ? '0 : consume_q[SW-1:0];
    found      = fc_q > c;
    c_next     = {1'b0, c} + 1'b1;
    cons_fetch = found ? CW'(c_next) : CW'(c);
    raddr      = rd_cmd_i.start ? slot_add(head_q, {1'b0, c}) : second_q;
    re         = rd_cmd_i.start || rd_cmd_i.second;
  end

  // Bookkeeping registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q       <= '0;
      fc_q         <= '0;
      consume_q    <= '0;
      vld_q        <= '0;
      last_start_q <= '0;
      found_q      <= 1'b0;
      skip_q       <= '0;
      second_q     <= '0;
      vld_rd_q     <= 1'b0;
    end else begin
      if (push_i) begin
        head_q    <= head2;
        fc_q      <= fc3;
        consume_q <= cons_push;
        if (add) begin
          vld_q[waddr] <= 1'b1;
          last_start_q <= pos_i;
        end
      end
      if (rd_cmd_i.start) begin
        consume_q <= cons_fetch;
        found_q   <= found;
        skip_q    <= neg ? cons_neg[KW-1:0] : '0;
        second_q  <= slot_add(head_q, c_next);
      end
      if (re) begin
        vld_rd_q <= vld_q[raddr];
      end
    end
  end

  // Entry never written reads as zero
  assign rd_word = vld_rd_q ? rdata : '0;

  always_ff @(posedge clk_i) begin
    if (rd_cmd_i.second) begin
      first_q <= rd_word;
    end
  end

  // Frame length is the ring distance to the following start
  always_comb begin
    if (rd_word >= first_q) begin
      dsum = {1'b0, rd_word} - {1'b0, first_q};
    end else begin
      dsum = {1'b0, rd_word} + AW1'(RING_BYTES) - {1'b0, first_q};
    end
  end

  assign offset_o      = found_q ? OW'(first_q) : '0;
  assign length_o      = found_q ? OW'(dsum[AW-1:0]) : '0;
  assign sts_o.found   = found_q;
  assign sts_o.skipped = skip_q;
  assign last_start_o  = last_start_q;

  dfb_ram #(
    .WIDTH(AW),
    .DEPTH(SLOTS)
  ) u_starts (
    .clk_i  (clk_i),
    .we_i   (push_i && add),
    .waddr_i(waddr),
    .wdata_i(pos_i),
    .re_i   (re),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  // Table never holds more frames than it has room for
  `DFB_ASSERT_STD(a_fc_bound, fc_q <= SW'(MAX_FRAMES), "frame count above table size")
  // Next frame to send never lies beyond the complete frames
  `DFB_ASSERT_STD(a_consume_le_fc,
    $signed(consume_q) <= $signed({{(CW - SW){1'b0}}, fc_q}), "consume index past frame count")
  // Drop count saturates before the signed range runs out
  `DFB_ASSERT_STD(a_consume_floor, consume_q != {1'b1, {(CW - 1){1'b0}}},
    "consume index below saturation floor")

endmodule

`default_nettype wire

// ----- sim/tb.sv -----
// Self-checking bench for delimiter_frame_buffer_core: stream words in, frame descriptors out.
// Depends on dfb_pkg and the RTL of the block; the expected descriptors come from a
// behavioral deframer kept inside the bench and updated on every accepted word.
`timescale 1ns / 1ps

module tb;
  import dfb_pkg::*;

  localparam int MAX_FRAMES  = 8;
  localparam int RING_BYTES  = 32768;
  localparam int SEP_MAX     = 8;
  localparam int SLOTS       = MAX_FRAMES + 1;
  localparam int PHASE_WORDS = 130;

  // one fetch answer, as the bench expects it
  typedef struct packed {
    logic                found;
    logic [OFFSET_W-1:0] offset;
    logic [OFFSET_W-1:0] length;
    logic [SKIP_W-1:0]   skipped;
  } frame_desc_t;

  typedef enum logic [1:0] {
    ROW_CFG,
    ROW_PUSH,
    ROW_FETCH
  } row_e;

  // directed row; no_frame marks a fetch whose answer is plainly empty
  typedef struct packed {
    row_e                 kind;
    cfg_reg_e             idx;
    logic [PATTERN_W-1:0] val;
    logic                 no_frame;
  } dir_row_t;

  logic                   clk_i         = 1'b0;
  logic                   rst_ni        = 1'b0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;
  logic                   s_axis_tuser  = FUNC_PUSH;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic                   m_axis_tuser;
  logic                   cfg_valid_i   = 1'b0;
  logic                   cfg_ready_o;
  logic [CFG_IDX_W-1:0]   cfg_index_i   = '0;
  logic [PATTERN_W-1:0]   cfg_data_i    = '0;

  int src_idle   = 0;
  int rx_idle    = 0;
  int words_sent = 0;
  int mismatches = 0;
  frame_desc_t pending_desc[$];

  delimiter_frame_buffer_core #(
    .MAX_FRAMES (MAX_FRAMES),
    .RING_BYTES (RING_BYTES),
    .SEP_MAX    (SEP_MAX)
  ) u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  always #2 clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // Deframer state, as the block should hold it
  // ---------------------------------------------------------------------------
  logic                    fixed_q  = 1'b1;
  logic [FRAME_SIZE_W-1:0] fsize_q  = FRAME_SIZE_RST;
  logic [SEP_LEN_W-1:0]    seplen_q = SEP_LEN_RST;
  logic [PATTERN_W-1:0]    sep_q    = '0;
  logic [63:0]             last8    = '0;  // newest byte on top
  int warm     = 0;
  int wr_pos   = 0;
  int starts [SLOTS] = '{default: 0};
  int head     = 0;
  int nframes  = 0;
  int send_idx = 0;  // negative while unsent frames were lost

  function automatic int slot(int i);
    return (head + i) % SLOTS;
  endfunction

  function automatic int ring_gap(int a, int b);
    return (a + RING_BYTES - b) % RING_BYTES;
  endfunction

  function automatic void drop_unsent(int n);
    int v;
    v = send_idx - n;
    send_idx = (v < -SKIP_MAX) ? -SKIP_MAX : v;
  endfunction

  function automatic void add_start(int pos, bit may_drop);
    if (nframes >= MAX_FRAMES) begin
      // full table: separator mode sheds the oldest frame, fixed mode ignores the cut
      if (!may_drop) return;
      head = slot(1);
      nframes--;
      drop_unsent(1);
    end
    nframes++;
    starts[slot(nframes)] = pos;
  endfunction

  function automatic void deframe_push(logic [7:0] b);
    int here;
    int eff;
    logic [63:0] win;
    logic [63:0] mask;
    here   = wr_pos;
    last8  = {b, last8[63:8]};
    if (warm < SEP_MAX) warm++;
    wr_pos = (here + 1) % RING_BYTES;

    if (fixed_q) begin
      if (fsize_q != '0 && int'(fsize_q) < RING_BYTES &&
          ring_gap(wr_pos, starts[slot(nframes)]) == int'(fsize_q))
        add_start(wr_pos, 1'b0);
    end else begin
      eff = (int'(seplen_q) > SEP_MAX) ? SEP_MAX : int'(seplen_q);
      if (eff != 0 && warm >= eff) begin
        win  = last8 >> (8 * (8 - eff));
        mask = (eff == 8) ? '1 : (64'd1 << (8 * eff)) - 64'd1;
        // cut sits on the first separator byte, possibly across the ring wrap
        if ((win & mask) == (sep_q & mask))
          add_start((here + RING_BYTES - (eff - 1)) % RING_BYTES, 1'b1);
      end
    end

    // near full: keep only the newest frame
    if (nframes >= MAX_FRAMES - 1 && nframes >= 1) begin
      head = slot(nframes - 1);
      drop_unsent(nframes - 1);
      nframes = 1;
    end
  endfunction

  function automatic frame_desc_t deframe_fetch();
    frame_desc_t d;
    int skip;
    int first;
    int next;
    d    = '0;
    skip = 0;
    if (send_idx < 0) begin
      skip     = (-send_idx > SKIP_MAX) ? SKIP_MAX : -send_idx;
      send_idx = 0;
    end
    if (nframes > send_idx) begin
      first    = starts[slot(send_idx)];
      next     = starts[slot(send_idx + 1)];
      d.found  = 1'b1;
      d.offset = first[OFFSET_W-1:0];
      d.length = OFFSET_W'(ring_gap(next, first));
      send_idx++;
    end
    d.skipped = SKIP_W'(skip);
    return d;
  endfunction

  function automatic void apply_reg(cfg_reg_e idx, logic [PATTERN_W-1:0] v);
    case (idx)
      REG_FIXED_MODE: fixed_q  = v[0];
      REG_FRAME_SIZE: fsize_q  = v[FRAME_SIZE_W-1:0];
      REG_SEP_LENGTH: seplen_q = v[SEP_LEN_W-1:0];
      default:        sep_q    = v;
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Drivers
  // ---------------------------------------------------------------------------
  task automatic send_word(func_e f, logic [7:0] b, bit no_frame);
    frame_desc_t d;
    while ($urandom_range(99) < src_idle) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= f;
    s_axis_tdata  <= b;
    do @(posedge clk_i); while (!s_axis_tready);
    words_sent++;
    if (f == FUNC_PUSH) begin
      deframe_push(b);
    end else begin
      d = deframe_fetch();
      if (no_frame) d = '0;
      pending_desc.push_back(d);
    end
  endtask

  // register writes only once the block has gone quiet
  task automatic write_reg(cfg_reg_e idx, logic [PATTERN_W-1:0] v);
    s_axis_tvalid <= 1'b0;
    while (pending_desc.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);  // a push word may still be in flight
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= v;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    apply_reg(idx, v);
  endtask

  task automatic load_setting(bit fixed_sel, int fsz, int slen, logic [PATTERN_W-1:0] pat);
    write_reg(REG_FIXED_MODE, PATTERN_W'(fixed_sel));
    write_reg(REG_FRAME_SIZE, PATTERN_W'(fsz));
    write_reg(REG_SEP_LENGTH, PATTERN_W'(slen));
    write_reg(REG_SEP_PATTERN, pat);
  endtask

  // leading bytes of the separator currently loaded
  task automatic push_sep(int n);
    for (int i = 0; i < n; i++) send_word(FUNC_PUSH, sep_q[8*i +: 8], 1'b0);
  endtask

  task automatic flag(string what, longint unsigned got, longint unsigned want);
    $display("%0t mismatch on %s: got 0x%0h, want 0x%0h", $time, what, got, want);
    mismatches++;
  endtask

  // ---------------------------------------------------------------------------
  // Descriptor checker and receiver stalls
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin : rx_side
    frame_desc_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_desc.size() == 0) begin
        flag("word with no fetch waiting", m_axis_tdata, 0);
      end else begin
        want = pending_desc.pop_front();
        if (m_axis_tuser != want.found) flag("frame_found", m_axis_tuser, want.found);
        if (m_axis_tdata[14:0] != want.offset)
          flag("frame_offset", m_axis_tdata[14:0], want.offset);
        if (m_axis_tdata[29:15] != want.length)
          flag("frame_length", m_axis_tdata[29:15], want.length);
        if (m_axis_tdata[37:30] != want.skipped)
          flag("skipped_frames", m_axis_tdata[37:30], want.skipped);
        if (m_axis_tdata[OUT_TDATA_W-1 -: OUT_PAD_W] != '0)
          flag("tdata pad", m_axis_tdata[OUT_TDATA_W-1 -: OUT_PAD_W], 0);
      end
    end
    m_axis_tready <= rst_ni && ($urandom_range(99) >= rx_idle);
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  initial begin
    dir_row_t dir_tbl[$];
    bit fixed_sel;
    int fsz;
    int slen;
    int eff;
    int k;
    int r;
    int n;
    int first_word;
    logic [PATTERN_W-1:0] pat;

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: reset state, early stream, separator length zero and oversize,
    // fixed size one, zero and max
    dir_tbl = '{
      '{ROW_FETCH, REG_FIXED_MODE,  64'h0, 1'b1},   // nothing after reset
      '{ROW_CFG,   REG_FIXED_MODE,  64'h0, 1'b0},
      '{ROW_CFG,   REG_SEP_LENGTH,  64'h2, 1'b0},
      '{ROW_CFG,   REG_SEP_PATTERN, 64'h0, 1'b0},
      '{ROW_PUSH,  REG_FIXED_MODE,  64'h00, 1'b0},
      '{ROW_FETCH, REG_FIXED_MODE,  64'h0, 1'b1},   // one byte: too early to match
      '{ROW_PUSH,  REG_FIXED_MODE,  64'h00, 1'b0},
      '{ROW_FETCH, REG_FIXED_MODE,  64'h0, 1'b0},
      '{ROW_CFG,   REG_SEP_LENGTH,  64'h0, 1'b0},
      '{ROW_PUSH,  REG_FIXED_MODE,  64'hFF, 1'b0},
      '{ROW_PUSH,  REG_FIXED_MODE,  64'h00, 1'b0},
      '{ROW_PUSH,  REG_FIXED_MODE,  64'h00, 1'b0},
      '{ROW_FETCH, REG_FIXED_MODE,  64'h0, 1'b1},   // zero length separator never cuts
      '{ROW_CFG,   REG_SEP_LENGTH,  64'hF, 1'b0},
      '{ROW_CFG,   REG_SEP_PATTERN, 64'h0000_0000_00FF_0000, 1'b0},
      '{ROW_PUSH,  REG_FIXED_MODE,  64'h00, 1'b0},
      '{ROW_PUSH,  REG_FIXED_MODE,  64'h00, 1'b0},
      '{ROW_PUSH,  REG_FIXED_MODE,  64'h00, 1'b0},
      '{ROW_FETCH, REG_FIXED_MODE,  64'h0, 1'b0},
      '{ROW_CFG,   REG_FIXED_MODE,  64'h1, 1'b0},
      '{ROW_CFG,   REG_FRAME_SIZE,  64'h1, 1'b0},
      '{ROW_PUSH,  REG_FIXED_MODE,  64'hA5, 1'b0},
      '{ROW_PUSH,  REG_FIXED_MODE,  64'h5A, 1'b0},
      '{ROW_FETCH, REG_FIXED_MODE,  64'h0, 1'b0},
      '{ROW_FETCH, REG_FIXED_MODE,  64'h0, 1'b0},
      '{ROW_CFG,   REG_FRAME_SIZE,  64'h0, 1'b0},
      '{ROW_PUSH,  REG_FIXED_MODE,  64'hFF, 1'b0},
      '{ROW_FETCH, REG_FIXED_MODE,  64'h0, 1'b0},
      '{ROW_CFG,   REG_FRAME_SIZE,  64'h1FFF, 1'b0},
      '{ROW_PUSH,  REG_FIXED_MODE,  64'h80, 1'b0},
      '{ROW_FETCH, REG_FIXED_MODE,  64'h0, 1'b0}
    };

    src_idle = 34;
    rx_idle  = 49;
    foreach (dir_tbl[i]) begin
      case (dir_tbl[i].kind)
        ROW_CFG:  write_reg(dir_tbl[i].idx, dir_tbl[i].val);
        ROW_PUSH: send_word(FUNC_PUSH, dir_tbl[i].val[7:0], 1'b0);
        default:  send_word(FUNC_FETCH, 8'($urandom), dir_tbl[i].no_frame);
      endcase
    end

    for (int regime = 0; regime < 3; regime++) begin
      src_idle = (regime == 0) ? 34 : (regime == 1) ? 49 : 0;
      rx_idle  = (regime == 0) ? 49 : (regime == 1) ? 34 : 0;

      if (regime == 1) begin
        // one-byte separator on nearly every byte: drops pile up past the skip limit
        load_setting(1'b0, 1024, 1, {56'h0, 8'($urandom)});
        repeat (320)
          send_word(FUNC_PUSH, ($urandom_range(9) == 0) ? 8'($urandom) : sep_q[7:0], 1'b0);
        repeat (3) send_word(FUNC_FETCH, 8'($urandom), 1'b0);
      end

      if (regime == 2) begin
        // longest separator, matched right after the switch
        pat = {$urandom, $urandom};
        load_setting(1'b0, 4096, 8, pat);
        push_sep(8);
        repeat (20) send_word(FUNC_PUSH, 8'($urandom), 1'b0);
        repeat (4) send_word(FUNC_FETCH, 8'($urandom), 1'b0);
      end

      for (int p = 0; p < 4; p++) begin
        k         = regime * 4 + p;
        fixed_sel = 1'b0;
        fsz       = $urandom_range(1, 64);
        slen      = $urandom_range(1, 8);
        pat       = {$urandom, $urandom};
        case (k % 6)
          0: begin
            fixed_sel = 1'b1;
            fsz       = $urandom_range(1, 12);
          end
          1: ;
          2: begin
            // repeated byte: overlapping separator matches
            slen = $urandom_range(2, 4);
            pat  = {8{8'($urandom)}};
          end
          3: begin
            fixed_sel = 1'b1;
            fsz       = $urandom_range(13, 40);
          end
          4: begin
            slen = (k < 6) ? 9 : 0;
            pat  = (k < 6) ? '1 : pat;
          end
          default: begin
            fixed_sel = 1'b1;
            fsz       = (k < 6) ? 0 : 8191;
          end
        endcase
        load_setting(fixed_sel, fsz, slen, pat);
        eff = (slen > SEP_MAX) ? SEP_MAX : slen;

        first_word = words_sent;
        while (words_sent - first_word < PHASE_WORDS) begin
          r = $urandom_range(99);
          if (r < 15) begin
            send_word(FUNC_FETCH, 8'($urandom), 1'b0);
          end else if (fixed_sel || r >= 88) begin
            send_word(FUNC_PUSH, 8'($urandom), 1'b0);
          end else if (r < 75) begin
            // payload then a full separator
            repeat ($urandom_range(12)) send_word(FUNC_PUSH, 8'($urandom), 1'b0);
            push_sep(eff);
          end else begin
            // separator cut short
            n = (eff > 1) ? $urandom_range(eff - 1) : 0;
            push_sep(n);
            send_word(FUNC_PUSH, 8'($urandom), 1'b0);
          end
        end
      end
    end

    s_axis_tvalid <= 1'b0;
    while (pending_desc.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (mismatches == 0 && pending_desc.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // watchdog
  initial begin
    #4_000_000;
    $display("TEST FAILED");
    $finish;
  end

endmodule
